// ===== hdl/multi_lane_i2c_master_top_assert.svh =====
// Assertion macros used by the checker file mli2c_chk.sv.
`ifndef MULTI_LANE_I2C_MASTER_TOP_ASSERT_SVH
`define MULTI_LANE_I2C_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MLI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MLI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/mli2c_pkg.sv =====
`default_nettype none
package mli2c_pkg;

  localparam int unsigned LANES   = 9;
  localparam int unsigned LaneW   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned SdaW    = 9;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  localparam logic [4:0] StepsStart = 5'd3;
  localparam logic [4:0] StepsStop  = 5'd3;
  localparam logic [4:0] StepsWrite = 5'd28;
  localparam logic [4:0] StepsRead  = 5'd21;
  localparam logic [4:0] WrBitSteps = 5'd24;
  localparam logic [4:0] RdBitSteps = 5'd16;
  localparam logic [4:0] RdAckStep  = 5'd17;
  localparam logic [4:0] RdClkHi    = 5'd18;
  localparam logic [4:0] RdClkLo    = 5'd19;
  localparam logic [4:0] RdEndStep  = 5'd20;
  localparam logic [4:0] WrAckLo    = 5'd24;
  localparam logic [4:0] WrAckRel   = 5'd25;
  localparam logic [4:0] WrAckHi    = 5'd26;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SUB_LOW  = 2'd0,
    SUB_DATA = 2'd1,
    SUB_HIGH = 2'd2
  } sub_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic [8:0] sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       byte_valid;
    logic [3:0] lane;
    logic [7:0] lane_byte;
    logic       last;
  } res_t;

  typedef logic [LANES-1:0][7:0] lane_bytes_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        rd_done;
    lane_bytes_t bytes;
  } q_ent_t;

endpackage
`default_nettype wire

// ===== hdl/mli2c_seq.sv =====
`default_nettype none
module mli2c_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  mli2c_pkg::tick_t     tick_i,
  output mli2c_pkg::q_ent_t    ent_o
);
  import mli2c_pkg::*;

  op_e         op_q, op_d, op_c;
  sub_e        sub_q, sub_d, sub_c;
  logic [4:0]  phase_q, phase_d, ph, ph_nx, total;
  logic [7:0]  tx_q, tx_d, tx_c;
  logic        ack_q, ack_d;
  lane_bytes_t lanes_q, lanes_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        rd_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_NONE;
      sub_q   <= SUB_LOW;
      phase_q <= '0;
      tx_q    <= '0;
      ack_q   <= 1'b0;
      lanes_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (accept_i) begin
      op_q    <= op_d;
      sub_q   <= sub_d;
      phase_q <= phase_d;
      tx_q    <= tx_d;
      ack_q   <= ack_d;
      lanes_q <= lanes_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  always_comb begin
    op_c    = op_q;
    sub_c   = sub_q;
    ph      = phase_q;
    tx_c    = tx_q;
    ack_d   = ack_q;
    if (op_q == OP_NONE &&
        tick_i.cmd inside {OP_START, OP_STOP, OP_WRITE, OP_READ}) begin
      op_c  = op_e'(tick_i.cmd);
      sub_c = SUB_LOW;
      ph    = '0;
      tx_c  = tick_i.tx_byte;
      ack_d = tick_i.send_ack;
    end

    op_d    = op_c;
    sub_d   = sub_c;
    tx_d    = tx_c;
    lanes_d = lanes_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rd_done = 1'b0;
    total   = 5'd1;

    unique case (op_c)
      OP_START: begin
        total = StepsStart;
        if (ph == 5'd0) begin
          scl_d = 1'b1; sda_d = 1'b1;
        end else if (ph == 5'd1) begin
          scl_d = 1'b1; sda_d = 1'b0;
        end else begin
          scl_d = 1'b0; sda_d = 1'b1;
        end
      end
      OP_STOP: begin
        total = StepsStop;
        if (ph == 5'd0) begin
          scl_d = 1'b0; sda_d = 1'b0;
        end else if (ph == 5'd1) begin
          scl_d = 1'b1; sda_d = 1'b0;
        end else begin
          scl_d = 1'b1; sda_d = 1'b1;
        end
      end
      OP_WRITE: begin
        total = StepsWrite;
        if (ph < WrBitSteps) begin
          unique case (sub_c)
            SUB_LOW: begin
              scl_d = 1'b0;
              sub_d = SUB_DATA;
            end
            SUB_DATA: begin
              sda_d = tx_c[7];
              sub_d = SUB_HIGH;
            end
            SUB_HIGH: begin
              scl_d = 1'b1;
              tx_d  = {tx_c[6:0], 1'b0};
              sub_d = SUB_LOW;
            end
            default: sub_d = SUB_LOW;
          endcase
        end else if (ph == WrAckLo) begin
          scl_d = 1'b0;
        end else if (ph == WrAckRel) begin
          sda_d = 1'b1;
        end else if (ph == WrAckHi) begin
          scl_d = 1'b1;
        end else begin
          scl_d = 1'b0;
        end
      end
      OP_READ: begin
        total = StepsRead;
        if (ph == 5'd0) begin
          sda_d   = 1'b1;
          scl_d   = 1'b0;
          lanes_d = '0;
        end else if (ph <= RdBitSteps) begin
          if (ph[0]) begin
            scl_d = 1'b1;
          end else begin
            for (int unsigned j = 0; j < LANES; j++) begin
              lanes_d[j] = {lanes_q[j][6:0], (j < SdaW) ? tick_i.sda_in[j] : 1'b0};
            end
            scl_d = 1'b0;
          end
        end else if (ph == RdAckStep) begin
          sda_d = ~ack_d;
        end else if (ph == RdClkHi) begin
          scl_d = 1'b1;
        end else if (ph == RdClkLo) begin
          scl_d = 1'b0;
        end else begin
          sda_d   = 1'b1;
          rd_done = (ph == RdEndStep);
        end
      end
      default: total = 5'd1;
    endcase

    ph_nx   = ph + 5'd1;
    phase_d = ph_nx;
    if (op_c == OP_NONE) begin
      phase_d = ph;
    end else if (ph_nx >= total) begin
      phase_d = '0;
      op_d    = OP_NONE;
    end

    ent_o.scl     = scl_d;
    ent_o.sda     = sda_d;
    ent_o.busy    = (op_d != OP_NONE);
    ent_o.rd_done = rd_done;
    ent_o.bytes   = lanes_d;
  end

endmodule
`default_nettype wire

// ===== hdl/mli2c_fifo.sv =====
`default_nettype none
module mli2c_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  mli2c_pkg::q_ent_t wr_data_i,
  input  logic              rd_en_i,
  output mli2c_pkg::q_ent_t rd_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import mli2c_pkg::*;

  q_ent_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QCW-1:0]   cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCW'(QDEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wptr_q <= wptr_q + QAW'(1);
      end
      if (rd_en_i) begin
        rptr_q <= rptr_q + QAW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mli2c_emit.sv =====
`default_nettype none
module mli2c_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  mli2c_pkg::q_ent_t q_data_i,
  output logic              q_pop_o,
  output logic              empty,
  input  logic              pop,
  output mli2c_pkg::res_t   res_o
);
  import mli2c_pkg::*;

  logic             vld_q;
  logic [LaneW-1:0] lane_q, lane_d;
  res_t             res_q, res_d;
  logic             load, lane_end;

  assign empty    = ~vld_q;
  assign res_o    = res_q;
  assign load     = (!vld_q || pop) && !q_empty_i;
  assign lane_end = !q_data_i.rd_done || (lane_q == LaneW'(LANES - 1));
  assign q_pop_o  = load && lane_end;

  always_comb begin
    res_d.scl_release = q_data_i.scl;
    res_d.sda_release = q_data_i.sda;
    res_d.busy_res    = q_data_i.busy;
    res_d.byte_valid  = q_data_i.rd_done;
    res_d.lane        = '0;
    res_d.lane_byte   = '0;
    res_d.last        = lane_end;
    if (q_data_i.rd_done) begin
      res_d.lane      = 4'(lane_q);
      res_d.lane_byte = q_data_i.bytes[lane_q];
    end
    lane_d = lane_end ? '0 : lane_q + LaneW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      lane_q <= '0;
    end else begin
      if (load) begin
        vld_q  <= 1'b1;
        lane_q <= lane_d;
      end else if (pop) begin
        vld_q  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/multi_lane_i2c_master_top.sv =====
// A tick's result is written into the queue and then into the result register before it shows on res_o.
// Throughput: one tick per cycle while the queue is not full; a tick that ends a read
// gives one result per lane, one per cycle while pop is held, from the single output register.
// A four-entry queue between sequencer and result side absorbs result stalls.
// Reset (rst_ni low, asynchronous): idle, SCL and SDA released, queue empty.
`default_nettype none
module multi_lane_i2c_master_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  mli2c_pkg::tick_t tick_i,
  output logic             empty,
  input  logic             pop,
  output mli2c_pkg::res_t  res_o
);
  import mli2c_pkg::*;

  q_ent_t seq_ent, q_head;
  logic   accept, q_pop, q_empty;

  assign accept = push && !full;

  mli2c_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .tick_i   (tick_i),
    .ent_o    (seq_ent)
  );

  mli2c_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (seq_ent),
    .rd_en_i   (q_pop),
    .rd_data_o (q_head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  mli2c_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_head),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

// ===== hdl/mli2c_chk.sv =====
`default_nettype none
`include "multi_lane_i2c_master_top_assert.svh"
module mli2c_chk (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic             full,
  input  mli2c_pkg::tick_t tick_i,
  input  logic             empty,
  input  logic             pop,
  input  mli2c_pkg::res_t  res_o
);
  import mli2c_pkg::*;

  logic unused_push;
  logic [$bits(tick_t)-1:0] unused_tick;

  assign unused_push = push;
  assign unused_tick = tick_i;

  `MLI_ASSERT_NXT(a_stall_hold, !empty && !pop, !empty && $stable(res_o))
  `MLI_ASSERT_NXT(a_lane_next, !empty && pop && res_o.byte_valid && !res_o.last, !empty && res_o.byte_valid && res_o.lane == $past(res_o.lane) + 4'd1)
  `MLI_ASSERT_IMP(a_full_has_out, full, !empty)
  `MLI_ASSERT_IMP(a_final_lane, !empty && res_o.byte_valid && res_o.lane == 4'(LANES - 1), res_o.last)

endmodule

bind multi_lane_i2c_master_top mli2c_chk u_chk (.*);
`default_nettype wire
